/* rtl/eicf_pkg.sv */
// ----------------------------------------------------------------------------
// eicf_pkg
// Types and constants shared by the edge interval capture framer modules.
// ----------------------------------------------------------------------------
package eicf_pkg;

   // request kinds as they arrive on the input channel
   localparam logic [1:0] REQ_EDGE = 2'd0;
   localparam logic [1:0] REQ_POLL = 2'd1;
   localparam logic [1:0] REQ_PULL = 2'd2;

   // configuration register indexes
   localparam logic [1:0] CSR_TIMEOUT       = 2'd0;
   localparam logic [1:0] CSR_CHECK_PERIOD  = 2'd1;
   localparam logic [1:0] CSR_BLOCK_SAMPLES = 2'd2;

   // configuration reset values
   localparam logic [31:0] TIMEOUT_RESET       = 32'd5000000;
   localparam logic [31:0] CHECK_PERIOD_RESET  = 32'd100000;
   localparam logic [7:0]  BLOCK_SAMPLES_RESET = 8'd255;

   // sample word format
   localparam logic [14:0] DELTA_MAX = 15'h7fff;

   // framing bytes and lengths
   localparam logic [7:0] BYTE_PAD  = 8'h00;
   localparam logic [7:0] BYTE_TYPE = 8'h01;
   localparam logic [7:0] BYTE_END  = 8'h80;
   localparam logic [9:0] HEADER_LEN = 10'd6;
   localparam logic [9:0] PREFIX_LEN = 10'd4;
   localparam logic [9:0] END_LEN    = 10'd2;

   // classified operation handed from front to back
   typedef enum logic [1:0] {
      OP_EDGE = 2'd0,
      OP_POLL = 2'd1,
      OP_PULL = 2'd2,
      OP_NONE = 2'd3
   } op_type;

   // what the transmitter is sending
   typedef enum logic [1:0] {
      KIND_IDLE   = 2'd0,
      KIND_HEADER = 2'd1,
      KIND_BLOCK  = 2'd2,
      KIND_FINAL  = 2'd3
   } tx_kind_type;

   typedef struct packed {
      op_type      op;
      logic [31:0] time_us;
      logic        rising;
   } req_item_type;

   typedef struct packed {
      logic [31:0] inactivity_timeout_us;
      logic [31:0] check_period_us;
      logic [7:0]  block_samples;
   } cfg_type;

   // result under construction between execute and output register
   typedef struct packed {
      logic       out_valid;
      logic [7:0] const_byte;
      logic       use_store;
      logic       high_half;
      logic       frame_end;
      logic       is_recording;
      logic       sample_dropped;
      logic       move;
   } stage_op_type;

   typedef struct packed {
      logic       out_valid;
      logic [7:0] out_byte;
      logic       frame_end;
      logic       is_recording;
      logic       sample_dropped;
   } rsp_item_type;

   // fixed header block bytes
   function automatic logic [7:0] header_byte(input logic [9:0] pos);
      logic [7:0] b;
      b = BYTE_PAD;
      if (pos == 10'd3) b = BYTE_TYPE;
      if (pos == 10'd5) b = BYTE_END;
      return b;
   endfunction

endpackage

/* rtl/eicf_ram.sv */
// ----------------------------------------------------------------------------
// eicf_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module eicf_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write or read, read data holds while disabled
   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem_ff[addr] <= wdata;
         end else begin
            rdata_ff <= mem_ff[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

/* rtl/eicf_front.sv */
// ----------------------------------------------------------------------------
// eicf_front
// Accepts request beats, classifies them and queues them for the back end.
// ----------------------------------------------------------------------------
module eicf_front
   import eicf_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [39:0]  req_tdata,   // time_us[31:0], rising[32], zero fill
   input  logic [1:0]   req_tuser,   // req_type[1:0]
   output logic         q_valid,
   output req_item_type q_item,
   input  logic         q_pop
);

   req_item_type entry_ff [2];
   logic         wr_sel_ff, wr_sel_in;
   logic         rd_sel_ff, rd_sel_in;
   logic [1:0]   count_ff, count_in;
   req_item_type item_c;
   logic         push;
   logic         pop;

   // classify the request kind
   always_comb begin
      item_c.time_us = req_tdata[31:0];
      item_c.rising  = req_tdata[32];
      case (req_tuser)
         REQ_EDGE: item_c.op = OP_EDGE;
         REQ_POLL: item_c.op = OP_POLL;
         REQ_PULL: item_c.op = OP_PULL;
         default:  item_c.op = OP_NONE;
      endcase
   end

   assign req_tready = (count_ff != 2'd2);
   assign push       = req_tvalid && req_tready;
   assign pop        = q_pop && (count_ff != 2'd0);
   assign q_valid    = (count_ff != 2'd0);
   assign q_item     = entry_ff[rd_sel_ff];

   // queue pointers
   always_comb begin
      wr_sel_in = push ? ~wr_sel_ff : wr_sel_ff;
      rd_sel_in = pop ? ~rd_sel_ff : rd_sel_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_sel_ff <= 1'b0;
         rd_sel_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_sel_ff <= wr_sel_in;
         rd_sel_ff <= rd_sel_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_sel_ff] <= item_c;
      end
   end

endmodule

/* rtl/eicf_back.sv */
// ----------------------------------------------------------------------------
// eicf_back
// Executes queued items: sample ring, block store, framing and result beats.
// ----------------------------------------------------------------------------
module eicf_back
   import eicf_pkg::*;
#(
   parameter int RING_DEPTH  = 1024,
   parameter int BLOCK_DEPTH = 256
) (
   input  logic         clock,
   input  logic         reset,
   input  cfg_type      cfg,
   input  logic         q_valid,
   input  req_item_type q_item,
   output logic         q_pop,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_item_type rsp_item
);

   localparam int RAW = $clog2(RING_DEPTH);
   localparam int BAW = $clog2(BLOCK_DEPTH);
   localparam logic [RAW-1:0] RING_LAST = RAW'(RING_DEPTH - 1);
   localparam logic [7:0] BLOCK_CAP = (BLOCK_DEPTH > 255) ? 8'd255 : 8'(BLOCK_DEPTH);

   // control state
   logic [RAW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [RAW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [7:0]     fill_ff, fill_in;
   logic [31:0]    last_edge_ff, last_edge_in;
   logic [31:0]    last_check_ff, last_check_in;
   logic           rec_ff, rec_in;
   logic           hdr_ff, hdr_in;
   logic [9:0]     tx_pos_ff, tx_pos_in;
   tx_kind_type    tx_kind_ff, tx_kind_in;

   // execute to output stage
   logic           st_valid_ff;
   stage_op_type   st_op_ff, st_op_in;
   logic [BAW-1:0] st_idx_ff;

   logic           rsp_valid_ff;
   rsp_item_type   rsp_item_ff;

   logic           st_adv;
   logic           a_fire;

   // transmitter decode
   logic [9:0]     two_n;
   logic [9:0]     blen;
   logic [9:0]     blen_f;
   logic [9:0]     data_end;
   logic [9:0]     tx_total;
   logic [9:0]     pos_next;
   logic [9:0]     pos_m4;
   logic           tx_has;
   logic           tx_done;
   logic           tx_use_store;
   logic [7:0]     tx_byte;
   logic           tx_fend;

   // execute helpers
   logic [31:0]    since_edge;
   logic [31:0]    since_check;
   logic [14:0]    delta_sat;
   logic [RAW-1:0] wr_next;
   logic [RAW-1:0] rd_next;
   logic [7:0]     lim0;
   logic [7:0]     lim;
   logic [7:0]     fill_inc;
   logic           move_c;
   logic           ring_en_c;
   logic           ring_we_c;
   logic           store_rd_c;

   // memory ports
   logic           ring_en;
   logic [RAW-1:0] ring_addr;
   logic [15:0]    ring_wdata;
   logic [15:0]    ring_rdata;
   logic           store_we;
   logic           store_en;
   logic [BAW-1:0] store_addr;
   logic [15:0]    store_rdata;

   assign st_adv = !rsp_valid_ff || rsp_ready;
   assign a_fire = q_valid && (!st_valid_ff || st_adv);
   assign q_pop  = a_fire;

   // transmitter byte selection from position, kind and fill
   always_comb begin
      two_n    = {1'b0, fill_ff, 1'b0};
      blen     = HEADER_LEN + two_n;
      blen_f   = (fill_ff != 8'd0) ? blen : 10'd0;
      data_end = PREFIX_LEN + two_n;
      pos_next = tx_pos_ff + 10'd1;
      pos_m4   = tx_pos_ff - PREFIX_LEN;
      case (tx_kind_ff)
         KIND_HEADER: tx_total = HEADER_LEN;
         KIND_BLOCK:  tx_total = blen;
         KIND_FINAL:  tx_total = blen_f + END_LEN;
         default:     tx_total = 10'd0;
      endcase
      tx_has       = tx_pos_ff < tx_total;
      tx_done      = pos_next >= tx_total;
      tx_use_store = 1'b0;
      tx_byte      = BYTE_PAD;
      if (tx_kind_ff == KIND_HEADER) begin
         tx_byte = header_byte(tx_pos_ff);
      end else if (tx_kind_ff == KIND_BLOCK ||
                   (tx_kind_ff == KIND_FINAL && tx_pos_ff < blen_f)) begin
         if (tx_pos_ff < 10'd2) begin
            tx_byte = BYTE_PAD;
         end else if (tx_pos_ff == 10'd2) begin
            tx_byte = BYTE_TYPE;
         end else if (tx_pos_ff == 10'd3) begin
            tx_byte = fill_ff;
         end else if (tx_pos_ff < data_end) begin
            tx_use_store = 1'b1;
         end else if (tx_pos_ff == data_end) begin
            tx_byte = BYTE_PAD;
         end else begin
            tx_byte = BYTE_END;
         end
      end else begin
         tx_byte = (tx_pos_ff == blen_f) ? BYTE_PAD : BYTE_END;
      end
      tx_fend = (pos_next == tx_total) ||
                (tx_kind_ff == KIND_FINAL && fill_ff != 8'd0 && pos_next == blen);
      if (!tx_has) begin
         tx_use_store = 1'b0;
         tx_byte      = BYTE_PAD;
         tx_fend      = 1'b0;
      end
   end

   // shared arithmetic for edges and polls
   always_comb begin
      since_edge  = q_item.time_us - last_edge_ff;
      since_check = q_item.time_us - last_check_ff;
      delta_sat   = (since_edge > {17'd0, DELTA_MAX}) ? DELTA_MAX : since_edge[14:0];
      wr_next     = (wr_ptr_ff == RING_LAST) ? '0 : wr_ptr_ff + 1'b1;
      rd_next     = (rd_ptr_ff == RING_LAST) ? '0 : rd_ptr_ff + 1'b1;
      lim0        = (cfg.block_samples == 8'd0) ? 8'd1 : cfg.block_samples;
      lim         = (lim0 > BLOCK_CAP) ? BLOCK_CAP : lim0;
      move_c      = (fill_ff < lim) && (rd_ptr_ff != wr_ptr_ff);
      fill_inc    = move_c ? fill_ff + 8'd1 : fill_ff;
   end

   // next control state for the item at the head of the queue
   always_comb begin
      wr_ptr_in     = wr_ptr_ff;
      rd_ptr_in     = rd_ptr_ff;
      fill_in       = fill_ff;
      last_edge_in  = last_edge_ff;
      last_check_in = last_check_ff;
      rec_in        = rec_ff;
      hdr_in        = hdr_ff;
      tx_pos_in     = tx_pos_ff;
      tx_kind_in    = tx_kind_ff;
      ring_en_c     = 1'b0;
      ring_we_c     = 1'b0;
      store_rd_c    = 1'b0;
      st_op_in      = '0;
      case (q_item.op)
         OP_EDGE: begin
            if (!rec_ff) begin
               rec_in = 1'b1;
               hdr_in = 1'b1;
            end
            if (wr_next == rd_ptr_ff) begin
               rd_ptr_in               = rd_next;
               st_op_in.sample_dropped = 1'b1;
            end
            ring_en_c    = 1'b1;
            ring_we_c    = 1'b1;
            wr_ptr_in    = wr_next;
            last_edge_in = q_item.time_us;
         end
         OP_PULL: begin
            if (tx_kind_ff != KIND_IDLE) begin
               st_op_in.out_valid  = tx_has;
               st_op_in.const_byte = tx_byte;
               st_op_in.use_store  = tx_use_store;
               st_op_in.high_half  = tx_pos_ff[0];
               st_op_in.frame_end  = tx_fend;
               store_rd_c          = tx_use_store;
               if (tx_done) begin
                  if (tx_kind_ff != KIND_HEADER) begin
                     fill_in = 8'd0;
                  end
                  tx_kind_in = KIND_IDLE;
                  tx_pos_in  = 10'd0;
               end else begin
                  tx_pos_in = pos_next;
               end
            end
         end
         OP_POLL: begin
            if (tx_kind_ff == KIND_IDLE) begin
               if (hdr_ff) begin
                  hdr_in        = 1'b0;
                  fill_in       = 8'd0;
                  last_check_in = q_item.time_us;
                  tx_kind_in    = KIND_HEADER;
                  tx_pos_in     = 10'd0;
               end else if (rec_ff) begin
                  if (move_c) begin
                     ring_en_c     = 1'b1;
                     st_op_in.move = 1'b1;
                     rd_ptr_in     = rd_next;
                  end
                  fill_in = fill_inc;
                  if (fill_inc >= lim) begin
                     tx_kind_in = KIND_BLOCK;
                     tx_pos_in  = 10'd0;
                  end else if (since_check >= cfg.check_period_us) begin
                     last_check_in = q_item.time_us;
                     if (since_edge > cfg.inactivity_timeout_us) begin
                        rec_in     = 1'b0;
                        wr_ptr_in  = '0;
                        rd_ptr_in  = '0;
                        tx_kind_in = KIND_FINAL;
                        tx_pos_in  = 10'd0;
                     end
                  end
               end
            end
         end
         default: begin
         end
      endcase
      st_op_in.is_recording = rec_in;
   end

   // control state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff     <= '0;
         rd_ptr_ff     <= '0;
         fill_ff       <= 8'd0;
         last_edge_ff  <= 32'd0;
         last_check_ff <= 32'd0;
         rec_ff        <= 1'b0;
         hdr_ff        <= 1'b0;
         tx_pos_ff     <= 10'd0;
         tx_kind_ff    <= KIND_IDLE;
      end else if (a_fire) begin
         wr_ptr_ff     <= wr_ptr_in;
         rd_ptr_ff     <= rd_ptr_in;
         fill_ff       <= fill_in;
         last_edge_ff  <= last_edge_in;
         last_check_ff <= last_check_in;
         rec_ff        <= rec_in;
         hdr_ff        <= hdr_in;
         tx_pos_ff     <= tx_pos_in;
         tx_kind_ff    <= tx_kind_in;
      end
   end

   // sample ring: edge writes at the write pointer, poll reads at the read pointer
   assign ring_en    = a_fire && ring_en_c;
   assign ring_addr  = ring_we_c ? wr_ptr_ff : rd_ptr_ff;
   assign ring_wdata = {q_item.rising, delta_sat};

   eicf_ram #(
      .WIDTH (16),
      .DEPTH (RING_DEPTH)
   ) u_ring (
      .clock (clock),
      .en    (ring_en),
      .we    (ring_we_c),
      .addr  (ring_addr),
      .wdata (ring_wdata),
      .rdata (ring_rdata)
   );

   // block store: moved sample written one stage late, pulls read ahead
   assign store_we   = st_valid_ff && st_adv && st_op_ff.move;
   assign store_en   = store_we || (a_fire && store_rd_c);
   assign store_addr = store_we ? st_idx_ff : pos_m4[BAW:1];

   eicf_ram #(
      .WIDTH (16),
      .DEPTH (BLOCK_DEPTH)
   ) u_store (
      .clock (clock),
      .en    (store_en),
      .we    (store_we),
      .addr  (store_addr),
      .wdata (ring_rdata),
      .rdata (store_rdata)
   );

   // execute stage register
   always_ff @(posedge clock) begin
      if (reset) begin
         st_valid_ff <= 1'b0;
      end else if (a_fire) begin
         st_valid_ff <= 1'b1;
      end else if (st_adv) begin
         st_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (a_fire) begin
         st_op_ff  <= st_op_in;
         st_idx_ff <= fill_ff[BAW-1:0];
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (st_adv) begin
         rsp_valid_ff <= st_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (st_adv && st_valid_ff) begin
         rsp_item_ff.out_valid      <= st_op_ff.out_valid;
         rsp_item_ff.out_byte       <= st_op_ff.use_store ?
                                       (st_op_ff.high_half ? store_rdata[15:8]
                                                           : store_rdata[7:0]) :
                                       st_op_ff.const_byte;
         rsp_item_ff.frame_end      <= st_op_ff.frame_end;
         rsp_item_ff.is_recording   <= st_op_ff.is_recording;
         rsp_item_ff.sample_dropped <= st_op_ff.sample_dropped;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

/* rtl/edge_interval_capture_framer_top.sv */
// A request beat passes the front queue, execute stage and output registers;
// one beat is taken per cycle unless rsp_tready stalls. Each item uses each
// RAM port at most once; a 2-entry queue plus output register absorb stalls.
// Reset clears pointers, fill, session and transmitter state and loads the
// configuration defaults; ring and block store contents are not cleared.
// ----------------------------------------------------------------------------
// edge_interval_capture_framer_top
// Edge interval capture with framed byte stream output and inactivity stop.
// ----------------------------------------------------------------------------
module edge_interval_capture_framer_top
   import eicf_pkg::*;
#(
   parameter int RING_DEPTH  = 1024,
   parameter int BLOCK_DEPTH = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // time_us[31:0], rising[32], zero fill
   input  logic [1:0]  req_tuser,   // req_type[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // out_byte[7:0], is_recording[8],
                                    // sample_dropped[9], zero fill
   output logic        rsp_tuser,   // out_valid
   output logic        rsp_tlast,   // frame_end
   input  logic        csr_we,
   input  logic [1:0]  csr_addr,
   input  logic [31:0] csr_wdata
);

   cfg_type      cfg_ff;
   logic         q_valid;
   req_item_type q_item;
   logic         q_pop;
   rsp_item_type rsp_item;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.inactivity_timeout_us <= TIMEOUT_RESET;
         cfg_ff.check_period_us       <= CHECK_PERIOD_RESET;
         cfg_ff.block_samples         <= BLOCK_SAMPLES_RESET;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_TIMEOUT:       cfg_ff.inactivity_timeout_us <= csr_wdata;
            CSR_CHECK_PERIOD:  cfg_ff.check_period_us       <= csr_wdata;
            CSR_BLOCK_SAMPLES: cfg_ff.block_samples         <= csr_wdata[7:0];
            default: begin
            end
         endcase
      end
   end

   eicf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop)
   );

   eicf_back #(
      .RING_DEPTH  (RING_DEPTH),
      .BLOCK_DEPTH (BLOCK_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_pop     (q_pop),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_item  (rsp_item)
   );

   // result beat packing
   assign rsp_tdata = {6'd0, rsp_item.sample_dropped, rsp_item.is_recording,
                       rsp_item.out_byte};
   assign rsp_tuser = rsp_item.out_valid;
   assign rsp_tlast = rsp_item.frame_end;

endmodule
